[hdl/text_console_glyph_writer_core_defines.svh]
`ifndef TEXT_CONSOLE_GLYPH_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_WRITER_CORE_DEFINES_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define TCGW_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked on the rising edge of clk outside reset
`define TCGW_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/tcgw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcgw_pkg;

  typedef enum logic [2:0] {
    CMD_PUT        = 3'd0,
    CMD_DRAW       = 3'd1,
    CMD_NEWLINE    = 3'd2,
    CMD_BACKSPACE  = 3'd3,
    CMD_SET_CURSOR = 3'd4,
    CMD_LOAD_FONT  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH = 3'd0,
    REG_LINE_PITCH   = 3'd1,
    REG_GLYPH_STRIDE = 3'd2,
    REG_TEXT_COLOR   = 3'd3,
    REG_CLEAR_COLOR  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_ADD,
    ST_ROW
  } state_t;

  localparam int unsigned CELL_ROWS = 16;
  localparam int unsigned CELL_COLS = 8;
  localparam int unsigned NEWLINE_X = 10;
  localparam int unsigned ROW_W     = $clog2(CELL_ROWS);
  localparam int unsigned BASE_W    = 14;
  localparam int unsigned OFF_W     = 24;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(CELL_ROWS - 1);
  localparam logic [7:0]       FULL_MASK = 8'hff;

  localparam logic [11:0] SCREEN_WIDTH_RST = 12'd640;
  localparam logic [11:0] LINE_PITCH_RST   = 12'd640;
  localparam logic [5:0]  GLYPH_STRIDE_RST = 6'd16;
  localparam logic [31:0] TEXT_COLOR_RST   = 32'hfff09ffe;
  localparam logic [31:0] CLEAR_COLOR_RST  = 32'h0000_0000;

endpackage

`default_nettype wire

[hdl/text_console_glyph_writer_core.sv]
// put, draw, backspace: the sequencer passes prep, mul and add, then one row write a cycle
// for 16 rows while the output is not stalled; in_stall holds until the last row is emitted;
// newline, set cursor and load font leave it idle; one shared multiplier and one 24-bit
// adder work in turn under the sequencer, the font store gives one byte per cycle
// rst_n is synchronous: cursor to 0, registers to their defaults, sequencer idle
// the font store is not cleared by reset
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_glyph_writer_core_defines.svh"

module text_console_glyph_writer_core
  import tcgw_pkg::*;
#(
  parameter int unsigned FONT_BYTES = 8192,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_command,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [11:0] in_pos_x,
  input  wire logic [11:0] in_pos_y,
  input  wire logic [12:0] in_font_address,
  input  wire logic [7:0]  in_font_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_pixel_offset,
  output logic [7:0]       out_pixel_mask,
  output logic [31:0]      out_pixel_color,
  output logic             out_last_row
);

  localparam int unsigned FA_W  = $clog2(FONT_BYTES);
  localparam int unsigned MUL_W = COORD_BITS + 12;
  localparam int unsigned EW    = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [COORD_BITS:0]    coord_c_t;
  typedef logic [FA_W-1:0]        faddr_t;
  typedef logic [FA_W+15:0]       rsum_t;
  typedef logic [MUL_W-1:0]       mul_t;
  typedef logic [MUL_W+OFF_W-1:0] mul_ext_t;
  typedef logic [OFF_W-1:0]       off_t;
  typedef logic [EW-1:0]          ext_t;
  typedef logic [COORD_BITS+11:0] sw_ext_t;

  function automatic coord_t add_rows_sat(coord_t y);
    coord_c_t v;
    v = coord_c_t'(y) + coord_c_t'(CELL_ROWS);
    return v[COORD_BITS] ? '1 : v[COORD_BITS-1:0];
  endfunction

  function automatic coord_t sub_rows_clamp(coord_t y);
    return (y < coord_t'(CELL_ROWS)) ? '0 : y - coord_t'(CELL_ROWS);
  endfunction

  // configuration
  logic [11:0] screen_width_r;
  logic [11:0] line_pitch_r;
  logic [5:0]  glyph_stride_r;
  logic [31:0] text_color_r;
  logic [31:0] clear_color_r;

  // sequencer and datapath
  state_t           state_r, state_nxt;
  cmd_t             cmd_r;
  logic [7:0]       code_r;
  coord_t           px_r, py_r;
  coord_t           cursor_x_r, cursor_x_nxt;
  coord_t           cursor_y_r, cursor_y_nxt;
  coord_t           col_r, col_nxt;
  coord_t           row_r, row_nxt;
  logic [7:0]       bs_mask_r, bs_mask_nxt;
  logic             is_clear_r;
  logic [BASE_W-1:0] base_r;
  off_t             prod_r;
  off_t             off_r;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;

  logic   in_acc;
  logic   emit;
  coord_t sw_coord;
  coord_t bs_x1, bs_y1;
  coord_t mul_a;
  logic [11:0] mul_b;
  mul_t   mul_p;
  off_t   add_a, add_b, add_sum;
  faddr_t rd_addr;
  faddr_t wr_addr;
  logic   wr_en;

  // font store
  logic [7:0] font_mem [FONT_BYTES];
  logic [7:0] mem_q_r;

  // output register
  logic        out_valid_r;
  off_t        out_offset_r;
  logic [7:0]  out_mask_r;
  logic [31:0] out_color_r;
  logic        out_last_r;

  assign in_acc   = in_valid && !in_stall;
  assign sw_coord = coord_t'(sw_ext_t'(screen_width_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r <= SCREEN_WIDTH_RST;
      line_pitch_r   <= LINE_PITCH_RST;
      glyph_stride_r <= GLYPH_STRIDE_RST;
      text_color_r   <= TEXT_COLOR_RST;
      clear_color_r  <= CLEAR_COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH: screen_width_r <= cfg_data[11:0];
        REG_LINE_PITCH:   line_pitch_r   <= cfg_data[11:0];
        REG_GLYPH_STRIDE: glyph_stride_r <= cfg_data[5:0];
        REG_TEXT_COLOR:   text_color_r   <= cfg_data;
        REG_CLEAR_COLOR:  clear_color_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority case (cmd_t'(in_command))
            CMD_PUT, CMD_DRAW, CMD_BACKSPACE: state_nxt = ST_PREP;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_ROW;
      ST_ROW: begin
        if (emit && row_cnt_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    emit        = (state_r == ST_ROW) && (!out_valid_r || !out_stall);
    row_cnt_nxt = '0;
    if (state_r == ST_ROW) begin
      row_cnt_nxt = emit ? row_cnt_r + 1'b1 : row_cnt_r;
    end
    // shared multiplier: glyph base in prep, row times pitch in mul
    if (state_r == ST_MUL) begin
      mul_a = row_r;
      mul_b = line_pitch_r;
    end else begin
      mul_a = coord_t'(code_r);
      mul_b = 12'(glyph_stride_r);
    end
    // shared adder: column in add, one scanline step per row beat
    if (state_r == ST_ADD) begin
      add_a = prod_r;
      add_b = off_t'(col_r);
    end else begin
      add_a = off_r;
      add_b = off_t'(line_pitch_r);
    end
  end

  assign mul_p   = mul_t'(mul_a) * mul_t'(mul_b);
  assign add_sum = add_a + add_b;
  // address follows the counter's next value so the registered byte lines up with the row
  assign rd_addr = faddr_t'(rsum_t'(base_r) + rsum_t'(row_cnt_nxt));
  assign wr_addr = faddr_t'(in_font_address);
  assign wr_en   = in_acc && (cmd_t'(in_command) == CMD_LOAD_FONT);

  // backspace: step back over the line start first
  always_comb begin
    if (cursor_x_r == '0) begin
      bs_x1 = sw_coord;
      bs_y1 = sub_rows_clamp(cursor_y_r);
    end else begin
      bs_x1 = cursor_x_r;
      bs_y1 = cursor_y_r;
    end
  end

  // cell position and cursor update
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    bs_mask_nxt  = bs_mask_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    if (in_acc) begin
      priority case (cmd_t'(in_command))
        CMD_NEWLINE: begin
          cursor_x_nxt = coord_t'(NEWLINE_X);
          cursor_y_nxt = add_rows_sat(cursor_y_r);
        end
        CMD_SET_CURSOR: begin
          cursor_x_nxt = coord_t'(in_pos_x);
          cursor_y_nxt = coord_t'(in_pos_y);
        end
        default: ;
      endcase
    end else if (state_r == ST_PREP) begin
      priority case (cmd_r)
        CMD_PUT: begin
          col_nxt = cursor_x_r;
          row_nxt = cursor_y_r;
          if (ext_t'(cursor_x_r) + ext_t'(2 * CELL_COLS) > ext_t'(screen_width_r)) begin
            cursor_x_nxt = '0;
            cursor_y_nxt = add_rows_sat(cursor_y_r);
          end else begin
            cursor_x_nxt = cursor_x_r + coord_t'(CELL_COLS);
          end
        end
        CMD_DRAW: begin
          col_nxt = px_r;
          row_nxt = py_r;
        end
        CMD_BACKSPACE: begin
          row_nxt = bs_y1;
          if (bs_x1 >= coord_t'(CELL_COLS)) begin
            col_nxt      = bs_x1 - coord_t'(CELL_COLS);
            bs_mask_nxt  = FULL_MASK;
            cursor_x_nxt = bs_x1 - coord_t'(CELL_COLS);
            cursor_y_nxt = bs_y1;
          end else begin
            // clipped at the left edge: keep only the columns right of zero
            col_nxt      = '0;
            bs_mask_nxt  = FULL_MASK << (4'(CELL_COLS) - 4'(bs_x1));
            cursor_x_nxt = sw_coord;
            cursor_y_nxt = sub_rows_clamp(bs_y1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      row_cnt_r  <= row_cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r      <= cmd_t'(in_command);
      code_r     <= in_char_code;
      px_r       <= coord_t'(in_pos_x);
      py_r       <= coord_t'(in_pos_y);
      is_clear_r <= (cmd_t'(in_command) == CMD_BACKSPACE);
    end
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    bs_mask_r <= bs_mask_nxt;
    if (state_r == ST_PREP) begin
      base_r <= mul_p[BASE_W-1:0];
    end
    if (state_r == ST_MUL) begin
      prod_r <= off_t'(mul_ext_t'(mul_p));
    end
    if (state_r == ST_ADD || emit) begin
      off_r <= add_sum;
    end
    if (emit) begin
      out_offset_r <= off_r;
      out_mask_r   <= is_clear_r ? bs_mask_r : mem_q_r;
      out_color_r  <= is_clear_r ? clear_color_r : text_color_r;
      out_last_r   <= (row_cnt_r == LAST_ROW);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_mem[wr_addr] <= in_font_data;
    end
    mem_q_r <= font_mem[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_offset = out_offset_r;
  assign out_pixel_mask   = out_mask_r;
  assign out_pixel_color  = out_color_r;
  assign out_last_row     = out_last_r;

  `TCGW_ASSERT_NXT(a_last_beat_idle, emit && (row_cnt_r == LAST_ROW), state_r == ST_IDLE, "sequencer did not return to idle after the last row")
  `TCGW_ASSERT_NXT(a_emit_loads_out, emit, out_valid_r, "row beat was not loaded into the output register")
  `TCGW_ASSERT_NXT(a_rows_start_zero, state_r == ST_ADD, (state_r == ST_ROW) && (row_cnt_r == '0), "row phase did not start at the top row")
  `TCGW_ASSERT_IMP(a_emit_only_in_rows, out_valid_r && !out_stall && out_last_r && (state_r == ST_ROW), row_cnt_r == '0, "new cell started before the last row beat of the previous one left")
  `TCGW_ASSERT_NXT(a_draw_enters_prep, in_acc && ((in_command == CMD_PUT) || (in_command == CMD_DRAW) || (in_command == CMD_BACKSPACE)), state_r == ST_PREP, "drawing beat did not start the sequencer")

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import tcgw_pkg::*;

  localparam int unsigned FONT_BYTES      = 8192;
  localparam int unsigned COORD_MAX       = 4095;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned BEATS_PER_PHASE = 10;

  // command codes the block ignores
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef enum {PACE_TX28_RX61, PACE_TX61_RX28, PACE_FREE} pace_t;
  typedef enum {CHK_MODEL, CHK_NO_MASK, CHK_ALL} typed_t;

  typedef struct {
    logic [2:0]  command;
    logic [7:0]  char_code;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [12:0] font_address;
    logic [7:0]  font_data;
  } console_beat_t;

  typedef struct {
    bit [23:0] offset;
    bit [7:0]  mask;
    bit [31:0] color;
    bit        last;
  } row_write_t;

  typedef struct {
    console_beat_t beat;
    typed_t        kind;
    row_write_t    first;
  } directed_step_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_command;
  logic [7:0]  in_char_code;
  logic [11:0] in_pos_x;
  logic [11:0] in_pos_y;
  logic [12:0] in_font_address;
  logic [7:0]  in_font_data;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] out_pixel_offset;
  logic [7:0]  out_pixel_mask;
  logic [31:0] out_pixel_color;
  logic        out_last_row;

  // console state as the block should hold it
  int unsigned scr_width;
  int unsigned pitch;
  int unsigned stride;
  bit [31:0]   fg_color;
  bit [31:0]   bg_color;
  int unsigned cur_x;
  int unsigned cur_y;
  bit [7:0]    glyph_bytes [FONT_BYTES];
  bit          glyph_known [FONT_BYTES];

  row_write_t     pending_rows[$];
  row_write_t     blank_row;
  directed_step_t plan[$];
  logic [7:0]     used_codes[$];
  int unsigned    mismatches;
  int unsigned    quiet_cycles;
  pace_t          pace;
  bit             hold_req;
  bit             hold_done;

  text_console_glyph_writer_core i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned rows_up(input int unsigned y);
    return (y + CELL_ROWS > COORD_MAX) ? COORD_MAX : y + CELL_ROWS;
  endfunction

  function automatic int unsigned rows_down(input int unsigned y);
    return (y < CELL_ROWS) ? 0 : y - CELL_ROWS;
  endfunction

  function automatic bit tx_gap();
    case (pace)
      PACE_TX28_RX61: return $urandom_range(0, 99) < 28;
      PACE_TX61_RX28: return $urandom_range(0, 99) < 61;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit rx_gap();
    case (pace)
      PACE_TX28_RX61: return $urandom_range(0, 99) < 61;
      PACE_TX61_RX28: return $urandom_range(0, 99) < 28;
      default:        return 1'b0;
    endcase
  endfunction

  // sixteen row writes of one cell, top row first
  task automatic expect_cell(input int unsigned col, input int unsigned row,
                             input bit from_font, input int unsigned base,
                             input bit [7:0] fill, input bit [31:0] color,
                             input typed_t kind, input row_write_t first);
    row_write_t w;
    bit [31:0]  off;
    for (int unsigned r = 0; r < CELL_ROWS; r++) begin
      // drawn row is not saturated, offset just wraps at 24 bits
      off = col + (row + r) * pitch;
      w.offset = off[23:0];
      w.mask = from_font ? glyph_bytes[(base + r) % FONT_BYTES] : fill;
      w.color = color;
      w.last = (r == CELL_ROWS - 1);
      if (r == 0 && kind != CHK_MODEL) begin
        w.offset = first.offset;
        w.color = first.color;
        if (kind == CHK_ALL)
          w.mask = first.mask;
      end
      pending_rows.push_back(w);
    end
  endtask

  task automatic predict_beat(input console_beat_t b, input typed_t kind,
                              input row_write_t first);
    int unsigned col;
    bit [7:0]    fill;
    case (b.command)
      CMD_PUT: begin
        expect_cell(cur_x, cur_y, 1'b1, b.char_code * stride, 8'h00, fg_color, kind, first);
        cur_x += CELL_COLS;
        if (cur_x + CELL_COLS > scr_width) begin
          cur_x = 0;
          cur_y = rows_up(cur_y);
        end
      end
      CMD_DRAW:
        expect_cell(b.pos_x, b.pos_y, 1'b1, b.char_code * stride, 8'h00, fg_color, kind,
                    first);
      CMD_NEWLINE: begin
        cur_x = NEWLINE_X;
        cur_y = rows_up(cur_y);
      end
      CMD_BACKSPACE: begin
        if (cur_x == 0) begin
          cur_x = scr_width;
          cur_y = rows_down(cur_y);
        end
        if (cur_x >= CELL_COLS) begin
          col = cur_x - CELL_COLS;
          fill = FULL_MASK;
        end else begin
          // clipped at the left edge: only the top cur_x bits survive
          col = 0;
          fill = 8'(32'hff << (CELL_COLS - cur_x));
        end
        expect_cell(col, cur_y, 1'b0, 0, fill, bg_color, kind, first);
        if (cur_x < CELL_COLS) begin
          cur_x = scr_width;
          cur_y = rows_down(cur_y);
        end else begin
          cur_x -= CELL_COLS;
        end
      end
      CMD_SET_CURSOR: begin
        cur_x = b.pos_x;
        cur_y = b.pos_y;
      end
      CMD_LOAD_FONT: begin
        glyph_bytes[b.font_address % FONT_BYTES] = b.font_data;
        glyph_known[b.font_address % FONT_BYTES] = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(input console_beat_t b, input typed_t kind,
                           input row_write_t first);
    @(negedge clk);
    while (tx_gap()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_command = b.command;
    in_char_code = b.char_code;
    in_pos_x = b.pos_x;
    in_pos_y = b.pos_y;
    in_font_address = b.font_address;
    in_font_data = b.font_data;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_beat(b, kind, first);
  endtask

  // load every glyph byte the code reads that has not been written yet
  task automatic ensure_glyph(input logic [7:0] code);
    console_beat_t b;
    int unsigned   a;
    for (int unsigned r = 0; r < CELL_ROWS; r++) begin
      a = (code * stride + r) % FONT_BYTES;
      if (!glyph_known[a]) begin
        b.command = CMD_LOAD_FONT;
        b.char_code = 8'($urandom_range(0, 255));
        b.pos_x = 12'($urandom_range(0, COORD_MAX));
        b.pos_y = 12'($urandom_range(0, COORD_MAX));
        b.font_address = 13'(a);
        b.font_data = 8'($urandom_range(0, 255));
        send_beat(b, CHK_MODEL, blank_row);
      end
    end
  endtask

  task automatic random_beat();
    console_beat_t b;
    int unsigned   pick;
    b.char_code = 8'($urandom_range(0, 255));
    b.pos_x = 12'($urandom_range(0, COORD_MAX));
    b.pos_y = 12'($urandom_range(0, COORD_MAX));
    b.font_address = 13'($urandom_range(0, FONT_BYTES - 1));
    b.font_data = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 36)
      b.command = CMD_PUT;
    else if (pick < 56)
      b.command = CMD_DRAW;
    else if (pick < 68)
      b.command = CMD_BACKSPACE;
    else if (pick < 76)
      b.command = CMD_NEWLINE;
    else if (pick < 84)
      b.command = CMD_SET_CURSOR;
    else if (pick < 94)
      b.command = CMD_LOAD_FONT;
    else
      b.command = pick[0] ? CMD_UNUSED_LO : CMD_UNUSED_HI;

    if (b.command == CMD_DRAW && $urandom_range(0, 4) == 0)
      b.pos_y = 12'(COORD_MAX - $urandom_range(0, 15));
    if (b.command == CMD_SET_CURSOR && $urandom_range(0, 1) == 1)
      b.pos_x = 12'($urandom_range(0, scr_width));
    if (b.command == CMD_PUT || b.command == CMD_DRAW) begin
      // mostly reuse glyphs already in the store, now and then a fresh one
      if (used_codes.size() != 0 && $urandom_range(0, 9) < 8)
        b.char_code = used_codes[$urandom_range(0, used_codes.size() - 1)];
      else
        used_codes.push_back(b.char_code);
      ensure_glyph(b.char_code);
    end
    send_beat(b, CHK_MODEL, blank_row);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_SCREEN_WIDTH: scr_width = val[11:0];
      REG_LINE_PITCH:   pitch = val[11:0];
      REG_GLYPH_STRIDE: stride = val[5:0];
      REG_TEXT_COLOR:   fg_color = val;
      REG_CLEAR_COLOR:  bg_color = val;
      default: ;
    endcase
  endtask

  task automatic set_phase(input int unsigned width, input int unsigned line,
                           input int unsigned gstride, input logic [31:0] fg,
                           input logic [31:0] bg);
    wait_idle();
    write_reg(REG_SCREEN_WIDTH, width);
    write_reg(REG_LINE_PITCH, line);
    write_reg(REG_GLYPH_STRIDE, gstride);
    write_reg(REG_TEXT_COLOR, fg);
    write_reg(REG_CLEAR_COLOR, bg);
  endtask

  // load rows take the address from the x column and the byte from the code column
  task automatic step(input logic [2:0] cmd, input int unsigned code, input int unsigned px,
                      input int unsigned py, input typed_t kind = CHK_MODEL,
                      input int unsigned off = 0, input int unsigned mask = 0,
                      input logic [31:0] color = 0);
    directed_step_t s;
    s.beat.command = cmd;
    s.beat.char_code = 8'(code);
    s.beat.pos_x = 12'(px);
    s.beat.pos_y = 12'(py);
    s.beat.font_address = 13'(px);
    s.beat.font_data = 8'(code);
    s.kind = kind;
    s.first.offset = 24'(off);
    s.first.mask = 8'(mask);
    s.first.color = color;
    s.first.last = 1'b0;
    plan.push_back(s);
  endtask

  // receiver side, with one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall = rx_gap();
    end
  end

  always @(posedge clk) begin : check_rows
    row_write_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_rows.size() == 0) begin
        report($sformatf("row write at offset %0d with none pending", out_pixel_offset));
      end else begin
        want = pending_rows.pop_front();
        if (out_pixel_offset !== want.offset)
          report($sformatf("pixel_offset %0d, expected %0d", out_pixel_offset, want.offset));
        if (out_pixel_mask !== want.mask)
          report($sformatf("pixel_mask %02h, expected %02h", out_pixel_mask, want.mask));
        if (out_pixel_color !== want.color)
          report($sformatf("pixel_color %08h, expected %08h", out_pixel_color, want.color));
        if (out_last_row !== want.last)
          report($sformatf("last_row %0b, expected %0b", out_last_row, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SCREEN_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_command = CMD_PUT;
    in_char_code = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_font_address = '0;
    in_font_data = '0;
    hold_req = 1'b0;
    pace = PACE_TX28_RX61;
    scr_width = SCREEN_WIDTH_RST;
    pitch = LINE_PITCH_RST;
    stride = GLYPH_STRIDE_RST;
    fg_color = TEXT_COLOR_RST;
    bg_color = CLEAR_COLOR_RST;
    cur_x = 0;
    cur_y = 0;

    // cursor starts at the origin, so the first backspace wraps to the screen width
    step(CMD_BACKSPACE, 0, 0, 0, CHK_ALL, 632, FULL_MASK, CLEAR_COLOR_RST);
    step(CMD_BACKSPACE, 0, 0, 0, CHK_ALL, 624, FULL_MASK, CLEAR_COLOR_RST);
    step(CMD_PUT, 8'h00, 0, 0, CHK_NO_MASK, 624, 0, TEXT_COLOR_RST);
    step(CMD_PUT, 8'hff, 0, 0, CHK_NO_MASK, 632, 0, TEXT_COLOR_RST);
    step(CMD_PUT, 8'h41, 0, 0, CHK_NO_MASK, 10240, 0, TEXT_COLOR_RST);
    step(CMD_NEWLINE, 0, 0, 0);
    step(CMD_PUT, 8'h41, 0, 0, CHK_NO_MASK, 20490, 0, TEXT_COLOR_RST);
    step(CMD_DRAW, 8'hff, 4095, 4095, CHK_NO_MASK, 2624895, 0, TEXT_COLOR_RST);
    step(CMD_DRAW, 8'h00, 0, 0, CHK_NO_MASK, 0, 0, TEXT_COLOR_RST);
    // only three columns left of the cursor get cleared
    step(CMD_SET_CURSOR, 0, 3, 0);
    step(CMD_BACKSPACE, 0, 0, 0, CHK_ALL, 0, 8'he0, CLEAR_COLOR_RST);
    step(CMD_SET_CURSOR, 0, 0, 4095);
    step(CMD_BACKSPACE, 0, 0, 0, CHK_ALL, 2611192, FULL_MASK, CLEAR_COLOR_RST);
    // second newline finds cursor y already pinned at the top of its range
    step(CMD_NEWLINE, 0, 0, 0);
    step(CMD_NEWLINE, 0, 0, 0);
    step(CMD_PUT, 8'h41, 0, 0, CHK_NO_MASK, 2620810, 0, TEXT_COLOR_RST);
    step(CMD_SET_CURSOR, 0, 4088, 4095);
    step(CMD_PUT, 8'hff, 0, 0, CHK_NO_MASK, 2624888, 0, TEXT_COLOR_RST);
    step(CMD_UNUSED_LO, 8'hff, 4095, 4095);
    step(CMD_UNUSED_HI, 8'h00, 0, 0);
    step(CMD_LOAD_FONT, 8'hff, 8191, 0);
    step(CMD_SET_CURSOR, 0, 4095, 0);
    step(CMD_BACKSPACE, 0, 0, 0, CHK_ALL, 4087, FULL_MASK, CLEAR_COLOR_RST);
    step(CMD_DRAW, 8'h00, 8, 1, CHK_NO_MASK, 648, 0, TEXT_COLOR_RST);

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].beat.command == CMD_PUT || plan[i].beat.command == CMD_DRAW)
        ensure_glyph(plan[i].beat.char_code);
      send_beat(plan[i].beat, plan[i].kind, plan[i].first);
    end

    set_phase(4095, 4095, 63, 32'hffff_ffff, 32'h0000_0000);
    repeat (BEATS_PER_PHASE) random_beat();

    // zero width, pitch and stride: every glyph reads the same bytes
    set_phase(0, 0, 0, 32'h0000_0000, 32'hffff_ffff);
    pace = PACE_TX61_RX28;
    repeat (BEATS_PER_PHASE) random_beat();

    set_phase($urandom_range(16, 320), $urandom_range(8, 4095), $urandom_range(16, 32),
              $urandom(), $urandom());
    pace = PACE_FREE;
    repeat (BEATS_PER_PHASE) random_beat();

    // narrow screen, and the receiver backs up the whole pipe for a while
    set_phase(7, 8, 32, $urandom(), $urandom());
    hold_req = 1'b1;
    repeat (BEATS_PER_PHASE) random_beat();

    wait_idle();
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/tcgw_pkg.sv
hdl/text_console_glyph_writer_core.sv
tb/tb.sv
